[hdl/twss_pkg.sv]
package twss_pkg;

    localparam int SAMPLE_DEPTH = 256;
    localparam int IDX_W = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int TIME_W = 48;
    localparam int SUM_W = VAL_W + CNT_W;
    localparam int SQ_W = 2 * VAL_W + CNT_W;
    localparam logic [TIME_W-1:0] WINDOW_RESET = 48'd10;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_ALL   = 2'd1,
        MODE_SUB   = 2'd2,
        MODE_FLUSH = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_EVICT_CHK,
        ST_P1_RD,
        ST_P1_ACC,
        ST_DIV1,
        ST_P2_RD,
        ST_P2_ACC,
        ST_DIV2,
        ST_SQRT,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input word
        logic add_write;   // append the sample (with drop when full)
        logic flush;
        logic rd_issue;    // issue read of slot oldest+k
        logic rd_oldest;   // issue read of the oldest slot
        logic evict;       // drop the oldest sample
        logic clr_acc;
        logic acc1;
        logic acc2;
        logic div1_start;
        logic div2_start;
        logic sqrt_start;
        logic step;        // advance one division or root step
        logic k_inc;
        logic publish;
    } t_cmd;

    // Status back to the controller.
    typedef struct packed {
        t_mode mode;
        logic  stale;      // oldest sample older than the window
        logic  count_zero;
        logic  k_last;     // k reached stored_count
        logic  n_zero;
        logic  unit_done;
    } t_status;

endpackage

[hdl/twss_ram.sv]
module twss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/twss_ctrl.sv]
module twss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  twss_pkg::t_status i_stat,
    output twss_pkg::t_cmd    o_cmd
);
    import twss_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // First cycle after capture: dispatch by mode.
                unique case (i_stat.mode)
                    MODE_ADD: begin
                        o_cmd.add_write = 1'b1;
                        n_state = ST_EVICT_RD;
                    end
                    MODE_FLUSH: begin
                        o_cmd.flush = 1'b1;
                        o_cmd.publish = 1'b1;
                        n_state = ST_IDLE;
                    end
                    default: begin
                        o_cmd.clr_acc = 1'b1;
                        n_state = ST_P1_RD;
                    end
                endcase
            end
            ST_EVICT_RD: begin
                o_cmd.rd_oldest = 1'b1;
                n_state = ST_EVICT_CHK;
            end
            ST_EVICT_CHK: begin
                if (!i_stat.count_zero && i_stat.stale) begin
                    o_cmd.evict = 1'b1;
                    n_state = ST_EVICT_RD;
                end else begin
                    o_cmd.publish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_P1_RD: begin
                if (i_stat.k_last) begin
                    if (i_stat.n_zero) begin
                        o_cmd.publish = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.div1_start = 1'b1;
                        n_state = ST_DIV1;
                    end
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = ST_P1_ACC;
                end
            end
            ST_P1_ACC: begin
                o_cmd.acc1 = 1'b1;
                o_cmd.k_inc = 1'b1;
                n_state = ST_P1_RD;
            end
            ST_DIV1: begin
                o_cmd.step = 1'b1;
                if (i_stat.unit_done) begin
                    o_cmd.step = 1'b0;
                    n_state = ST_P2_RD;
                end
            end
            ST_P2_RD: begin
                if (i_stat.k_last) begin
                    o_cmd.div2_start = 1'b1;
                    n_state = ST_DIV2;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = ST_P2_ACC;
                end
            end
            ST_P2_ACC: begin
                o_cmd.acc2 = 1'b1;
                o_cmd.k_inc = 1'b1;
                n_state = ST_P2_RD;
            end
            ST_DIV2: begin
                o_cmd.step = 1'b1;
                if (i_stat.unit_done) begin
                    o_cmd.step = 1'b0;
                    o_cmd.sqrt_start = 1'b1;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                o_cmd.step = 1'b1;
                if (i_stat.unit_done) begin
                    o_cmd.step = 1'b0;
                    o_cmd.publish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

[hdl/twss_dp.sv]
module twss_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  twss_pkg::t_cmd                i_cmd,
    output twss_pkg::t_status             o_stat,
    input  logic [1:0]                    i_mode,
    input  logic [twss_pkg::VAL_W-1:0]    i_sample_value,
    input  logic [twss_pkg::TIME_W-1:0]   i_sample_time,
    input  logic [twss_pkg::TIME_W-1:0]   i_current_time,
    input  logic [twss_pkg::TIME_W-1:0]   i_subwindow_length,
    input  logic [twss_pkg::TIME_W-1:0]   i_window_length,
    output logic                          o_valid,
    output logic [8:0]                    o_sample_count,
    output logic [31:0]                   o_mean_value,
    output logic [31:0]                   o_max_value,
    output logic [31:0]                   o_min_value,
    output logic [31:0]                   o_deviation_value,
    output logic [31:0]                   o_flush_count,
    output logic                          o_overflow_drop
);
    import twss_pkg::*;

    localparam int DIV_STEPS = 2 * VAL_W + CNT_W;
    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    // Captured input word.
    t_mode              r_mode;
    logic [VAL_W-1:0]   r_val;
    logic [TIME_W-1:0]  r_stime, r_now, r_sub;

    // Ring state.
    logic [IDX_W-1:0]   r_oldest;
    logic [CNT_W-1:0]   r_count;
    logic [31:0]        r_flushes;
    logic               r_drop;

    // Walk and accumulation.
    logic [CNT_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_n;
    logic [SUM_W-1:0]   r_sum;
    logic [VAL_W-1:0]   r_mx, r_mn, r_mean;
    logic [SQ_W-1:0]    r_sq;
    logic               r_div1_busy;

    // Shared restoring divider / root unit.
    logic [SQ_W-1:0]    r_q;       // dividend shifting into quotient
    logic [CNT_W:0]     r_rem;
    logic [STEP_W-1:0]  r_steps;
    logic               r_is_root;
    logic [63:0]        r_rv;      // root operand
    logic [63:0]        r_res, r_bit;

    // RAMs.
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr, w_raddr;
    logic [VAL_W-1:0]   w_rval;
    logic [TIME_W-1:0]  w_rtime;

    logic [CNT_W-1:0]   w_cnt_eff;
    logic [IDX_W-1:0]   w_old_eff;
    logic [CNT_W-1:0]   w_k_sum;
    logic               w_sel;
    logic [VAL_W-1:0]   w_diff;
    logic [2*VAL_W-1:0] w_d2;
    logic [CNT_W:0]     w_trial;
    logic [63:0]        w_rb;

    // Full ring: drop oldest before appending.
    assign w_cnt_eff = (r_count == CNT_W'(SAMPLE_DEPTH)) ? CNT_W'(SAMPLE_DEPTH - 1) : r_count;
    assign w_old_eff = (r_count == CNT_W'(SAMPLE_DEPTH)) ? r_oldest + IDX_W'(1) : r_oldest;
    assign w_k_sum   = CNT_W'(r_oldest) + r_k;
    assign w_we      = i_cmd.add_write;
    assign w_waddr   = w_old_eff + w_cnt_eff[IDX_W-1:0];
    assign w_raddr   = i_cmd.rd_oldest ? r_oldest : w_k_sum[IDX_W-1:0];

    twss_ram #(.WIDTH(VAL_W), .DEPTH(SAMPLE_DEPTH)) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(r_val),
        .i_raddr(w_raddr),
        .o_rdata(w_rval)
    );

    twss_ram #(.WIDTH(TIME_W), .DEPTH(SAMPLE_DEPTH)) u_time_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(r_stime),
        .i_raddr(w_raddr),
        .o_rdata(w_rtime)
    );

    assign w_sel  = (r_mode != MODE_SUB) ||
                    (({1'b0, w_rtime} + {1'b0, r_sub}) >= {1'b0, r_now});
    assign w_diff = (w_rval > r_mean) ? (w_rval - r_mean) : (r_mean - w_rval);
    assign w_d2   = w_diff * w_diff;
    assign w_trial = {r_rem[CNT_W-1:0], r_q[SQ_W-1]} - {1'b0, r_n};
    assign w_rb   = r_res + r_bit;

    assign o_stat.mode       = r_mode;
    assign o_stat.stale      = ({1'b0, w_rtime} + {1'b0, i_window_length}) < {1'b0, r_now};
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.k_last     = (r_k == r_count);
    assign o_stat.n_zero     = (r_n == '0);
    assign o_stat.unit_done  = r_is_root ? (r_bit == '0) : (r_steps == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest  <= '0;
            r_count   <= '0;
            r_flushes <= '0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= i_cmd.publish;
            if (i_cmd.add_write) begin
                r_oldest <= w_old_eff;
                r_count  <= w_cnt_eff + CNT_W'(1);
            end
            if (i_cmd.evict) begin
                r_oldest <= r_oldest + IDX_W'(1);
                r_count  <= r_count - CNT_W'(1);
            end
            if (i_cmd.flush) begin
                r_oldest  <= '0;
                r_count   <= '0;
                r_flushes <= r_flushes + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= t_mode'(i_mode);
            r_val   <= i_sample_value;
            r_stime <= i_sample_time;
            r_now   <= i_current_time;
            r_sub   <= i_subwindow_length;
        end
        if (i_cmd.add_write) begin
            r_drop <= (r_count == CNT_W'(SAMPLE_DEPTH));
        end
        if (i_cmd.clr_acc) begin
            r_k   <= '0;
            r_n   <= '0;
            r_sum <= '0;
            r_sq  <= '0;
            r_mx  <= '0;
            r_mn  <= '1;
        end
        if (i_cmd.div1_start) begin
            r_k <= '0;
        end
        if (i_cmd.k_inc) begin
            r_k <= r_k + CNT_W'(1);
        end
        if (i_cmd.acc1 && w_sel) begin
            r_n   <= r_n + CNT_W'(1);
            r_sum <= r_sum + SUM_W'(w_rval);
            if (w_rval > r_mx) r_mx <= w_rval;
            if (w_rval < r_mn) r_mn <= w_rval;
        end
        if (i_cmd.acc2 && w_sel) begin
            r_sq <= r_sq + SQ_W'(w_d2);
        end
        // Shared divider: one quotient bit per step.
        if (i_cmd.div1_start) begin
            r_q       <= SQ_W'(r_sum);
            r_rem     <= '0;
            r_steps   <= STEP_W'(DIV_STEPS);
            r_is_root <= 1'b0;
        end else if (i_cmd.div2_start) begin
            r_q       <= r_sq;
            r_rem     <= '0;
            r_steps   <= STEP_W'(DIV_STEPS);
            r_is_root <= 1'b0;
        end else if (i_cmd.sqrt_start) begin
            r_rv      <= r_q[63:0];
            r_res     <= '0;
            r_bit     <= 64'h4000_0000_0000_0000;
            r_is_root <= 1'b1;
        end else if (i_cmd.step && !r_is_root) begin
            if (!w_trial[CNT_W]) begin
                r_rem <= w_trial;
                r_q   <= {r_q[SQ_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[CNT_W-1:0], r_q[SQ_W-1]};
                r_q   <= {r_q[SQ_W-2:0], 1'b0};
            end
            r_steps <= r_steps - STEP_W'(1);
        end else if (i_cmd.step && r_is_root) begin
            if (r_rv >= w_rb) begin
                r_rv  <= r_rv - w_rb;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // The mean is the reference for the second pass, so it is latched at the
    // edge where the controller leaves the first division, before that pass begins.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div1_busy <= 1'b0;
        end else if (i_cmd.div1_start) begin
            r_div1_busy <= 1'b1;
        end else if (r_div1_busy && r_steps == '0 && !r_is_root) begin
            r_div1_busy <= 1'b0;
            r_mean      <= r_q[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            o_sample_count    <= 9'd0;
            o_mean_value      <= '0;
            o_max_value       <= '0;
            o_min_value       <= '0;
            o_deviation_value <= '0;
            o_overflow_drop   <= 1'b0;
            o_flush_count     <= (r_mode == MODE_FLUSH) ? r_flushes + 32'd1 : r_flushes;
            if (r_mode == MODE_ADD) begin
                o_sample_count  <= 9'(r_count);
                o_overflow_drop <= r_drop;
            end else if (r_mode != MODE_FLUSH) begin
                o_sample_count <= 9'(r_n);
                if (r_n != '0) begin
                    o_mean_value      <= r_mean;
                    o_max_value       <= r_mx;
                    o_min_value       <= r_mn;
                    o_deviation_value <= r_res[VAL_W-1:0];
                end
            end
        end
    end
endmodule

[hdl/time_window_sample_statistics.sv]
// An insert appends the sample, then evicts stale samples one at a time; a flush
// empties the ring. A query makes two walks through the sample memories, with
// two 73-step bit-serial divisions and a 32-step square root, over a ring of up to
// 256 samples; a query whose set is empty ends after the first walk.
// One word is in flight at a time, so no new word is taken while busy; the
// receiver cannot stall. Synchronous active-low reset empties the ring, window_length 10.
module time_window_sample_statistics (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_sample_value,
    input  logic [47:0] i_sample_time,
    input  logic [47:0] i_current_time,
    input  logic [47:0] i_subwindow_length,
    output logic        o_valid,
    output logic [8:0]  o_sample_count,
    output logic [31:0] o_mean_value,
    output logic [31:0] o_max_value,
    output logic [31:0] o_min_value,
    output logic [31:0] o_deviation_value,
    output logic [31:0] o_flush_count,
    output logic        o_overflow_drop,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import twss_pkg::*;

    t_cmd              w_cmd;
    t_status           w_stat;
    logic [TIME_W-1:0] r_window;

    // The single register, window_length, sits at address 0 of a 64-bit port.
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {16'd0, r_window} : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            r_window <= pwdata[TIME_W-1:0];
        end
    end

    // The controller sequences the walks and the shared divide/root unit.
    twss_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .o_busy (busy),
        .i_stat (w_stat),
        .o_cmd  (w_cmd)
    );

    // The datapath holds the sample memories, accumulators and the result.
    twss_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_mode            (i_mode),
        .i_sample_value    (i_sample_value),
        .i_sample_time     (i_sample_time),
        .i_current_time    (i_current_time),
        .i_subwindow_length(i_subwindow_length),
        .i_window_length   (r_window),
        .o_valid           (o_valid),
        .o_sample_count    (o_sample_count),
        .o_mean_value      (o_mean_value),
        .o_max_value       (o_max_value),
        .o_min_value       (o_min_value),
        .o_deviation_value (o_deviation_value),
        .o_flush_count     (o_flush_count),
        .o_overflow_drop   (o_overflow_drop)
    );
endmodule

[tb/time_window_sample_statistics_tb.sv]
`timescale 1ns / 100ps

module time_window_sample_statistics_tb;

    import twss_pkg::*;

    localparam int          CLK_PERIOD  = 10;
    localparam int          CYCLE_LIMIT = 8000000;
    localparam logic [47:0] TIME_MAX    = 48'hFFFF_FFFF_FFFF;

    // One command word as it is presented on the input ports.
    typedef struct {
        t_mode       mode;
        logic [31:0] sample_value;
        logic [47:0] sample_time;
        logic [47:0] current_time;
        logic [47:0] subwindow_length;
    } t_stat_word;

    // One result word as it appears while o_valid is high.
    typedef struct {
        logic [8:0]  sample_count;
        logic [31:0] mean_value;
        logic [31:0] max_value;
        logic [31:0] min_value;
        logic [31:0] deviation_value;
        logic [31:0] flush_count;
        logic        overflow_drop;
    } t_stat_result;

    // The ledger mirrors the sample ring and predicts the result of each accepted
    // word. Results come back strictly in order, so a plain FIFO of predictions
    // is enough to line them up with the block's output.
    class window_stats_ledger;
        logic [31:0]  value_mem [SAMPLE_DEPTH];
        logic [47:0]  stamp_mem [SAMPLE_DEPTH];
        logic [7:0]   head;
        int           held;
        logic [31:0]  flushes;
        logic [47:0]  window;
        t_stat_result awaited [$];
        int           errors;

        function new();
            head    = '0;
            held    = 0;
            flushes = '0;
            window  = WINDOW_RESET;
            errors  = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Integer square root by the usual digit-pair method; floor of the root.
        function logic [31:0] root_floor(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] bitv;
            res  = '0;
            bitv = 64'h4000_0000_0000_0000;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res[31:0];
        endfunction

        // Count, truncated mean, extremes and population deviation over the
        // stored samples, optionally limited to those young enough.
        function void window_stats(bit sub, logic [47:0] sublen, logic [47:0] now,
                                   ref t_stat_result r);
            logic [63:0]  n;
            logic [63:0]  sum;
            logic [31:0]  mx;
            logic [31:0]  mn;
            logic [31:0]  mean;
            logic [63:0]  d;
            logic [127:0] sq_sum;
            logic [127:0] var_q;
            logic [7:0]   s;
            n      = '0;
            sum    = '0;
            mx     = '0;
            mn     = '1;
            sq_sum = '0;
            for (int k = 0; k < held; k++) begin
                s = head + 8'(k);
                if (!sub || ({1'b0, stamp_mem[s]} + {1'b0, sublen} >= {1'b0, now})) begin
                    n   = n + 1;
                    sum = sum + value_mem[s];
                    if (value_mem[s] > mx) mx = value_mem[s];
                    if (value_mem[s] < mn) mn = value_mem[s];
                end
            end
            if (n == 0) return;
            mean = 32'(sum / n);
            for (int k = 0; k < held; k++) begin
                s = head + 8'(k);
                if (!sub || ({1'b0, stamp_mem[s]} + {1'b0, sublen} >= {1'b0, now})) begin
                    d = (value_mem[s] > mean) ? 64'(value_mem[s] - mean)
                                              : 64'(mean - value_mem[s]);
                    sq_sum = sq_sum + 128'(d * d);
                end
            end
            var_q             = sq_sum / 128'(n);
            r.sample_count    = 9'(n);
            r.mean_value      = mean;
            r.max_value       = mx;
            r.min_value       = mn;
            r.deviation_value = root_floor(var_q[63:0]);
        endfunction

        function void note_word(t_stat_word w);
            t_stat_result r;
            logic [7:0]   s;
            r = '{default: '0};
            case (w.mode)
                MODE_ADD: begin
                    if (held >= SAMPLE_DEPTH) begin
                        held            = SAMPLE_DEPTH - 1;
                        head            = head + 8'd1;
                        r.overflow_drop = 1'b1;
                    end
                    s            = head + 8'(held);
                    value_mem[s] = w.sample_value;
                    stamp_mem[s] = w.sample_time;
                    held++;
                    while (held > 0 && ({1'b0, stamp_mem[head]} + {1'b0, window}
                                        < {1'b0, w.current_time})) begin
                        head = head + 8'd1;
                        held--;
                    end
                    r.sample_count = 9'(held);
                end
                MODE_ALL: window_stats(1'b0, '0, w.current_time, r);
                MODE_SUB: window_stats(1'b1, w.subwindow_length, w.current_time, r);
                default: begin
                    held    = 0;
                    head    = '0;
                    flushes = flushes + 32'd1;
                end
            endcase
            r.flush_count = flushes;
            awaited = {awaited, r};
        endfunction

        function void check_result(t_stat_result got);
            t_stat_result want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result word with nothing awaited");
                return;
            end
            want = awaited.pop_front();
            if (got.sample_count !== want.sample_count || got.mean_value !== want.mean_value
                || got.max_value !== want.max_value || got.min_value !== want.min_value
                || got.deviation_value !== want.deviation_value
                || got.flush_count !== want.flush_count
                || got.overflow_drop !== want.overflow_drop) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: count %0d/%0d mean %h/%h max %h/%h min %h/%h",
                             want.sample_count, got.sample_count, want.mean_value,
                             got.mean_value, want.max_value, got.max_value,
                             want.min_value, got.min_value);
                    $display("          dev %h/%h flushes %0d/%0d drop %b/%b (want/got)",
                             want.deviation_value, got.deviation_value,
                             want.flush_count, got.flush_count,
                             want.overflow_drop, got.overflow_drop);
                end
            end
        endfunction
    endclass

    // All block inputs start at known values; the reset is held low from time zero.
    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        start              = 1'b0;
    logic [1:0]  i_mode             = '0;
    logic [31:0] i_sample_value     = '0;
    logic [47:0] i_sample_time      = '0;
    logic [47:0] i_current_time     = '0;
    logic [47:0] i_subwindow_length = '0;
    logic        psel               = 1'b0;
    logic        penable            = 1'b0;
    logic        pwrite             = 1'b0;
    logic [0:0]  paddr              = '0;
    logic [63:0] pwdata             = '0;
    logic        busy;
    logic        o_valid;
    logic [8:0]  o_sample_count;
    logic [31:0] o_mean_value;
    logic [31:0] o_max_value;
    logic [31:0] o_min_value;
    logic [31:0] o_deviation_value;
    logic [31:0] o_flush_count;
    logic        o_overflow_drop;
    logic [63:0] prdata;
    logic        pready;

    window_stats_ledger ledger;
    int                 cycle_count = 0;
    int                 burst_left  = 0;
    logic [47:0]        tick_now    = '0;   // running notion of the present time

    time_window_sample_statistics i_dut (.*);

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver cannot stall the block, so every strobed word is taken at
    // the edge that closes its cycle. Sampling at the edge sees pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            ledger.check_result('{o_sample_count, o_mean_value, o_max_value, o_min_value,
                                  o_deviation_value, o_flush_count, o_overflow_drop});
        end
    end

    // Present one word and hold it until the block takes it. The word is taken
    // at the first edge that sees start high and busy low. Start is left high
    // so a back-to-back word never toggles it within one time step.
    task automatic send_word(input t_stat_word w);
        start              <= 1'b1;
        i_mode             <= w.mode;
        i_sample_value     <= w.sample_value;
        i_sample_time      <= w.sample_time;
        i_current_time     <= w.current_time;
        i_subwindow_length <= w.subwindow_length;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        ledger.note_word(w);
        // Bursts of random length separated by random idle gaps; some bursts
        // are long enough to give stretches with no idling at all.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Wait for every predicted result, plus a short margin so the block is idle.
    task automatic drain();
        start <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write of window_length: setup cycle, then access cycle.
    task automatic write_window(input logic [47:0] len);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= '0;
        pwdata  <= {16'h0, len};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ledger.window = len;
        @(posedge i_clk);
    endtask

    function automatic t_stat_word make_word(t_mode m, logic [31:0] v, logic [47:0] st,
                                             logic [47:0] ct, logic [47:0] sub);
        t_stat_word w;
        w = '{m, v, st, ct, sub};
        return w;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    // Random traffic. Most words follow a slowly advancing clock so that
    // eviction and subwindow limits land among the stored samples; a few use
    // wild timestamps or times to exercise the far ends of the 48-bit fields.
    task automatic run_random(input int words, input int add_pct, input int flush_pct);
        t_stat_word  w;
        int          pick;
        logic [31:0] v;
        for (int i = 0; i < words; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < add_pct)                   w.mode = MODE_ADD;
            else if (pick < add_pct + flush_pct)  w.mode = MODE_FLUSH;
            else if (pick[0])                     w.mode = MODE_ALL;
            else                                  w.mode = MODE_SUB;
            case ($urandom_range(0, 5))
                0:       v = $urandom_range(0, 15);
                1:       v = 32'hFFFF_FFFF - $urandom_range(0, 15);
                2:       v = 32'h0001_0000 + $urandom_range(0, 32'h0004_0000);
                default: v = $urandom();
            endcase
            w.sample_value = v;
            if ($urandom_range(0, 60) == 0) tick_now = rand48();
            else                            tick_now = tick_now + $urandom_range(0, 4);
            w.sample_time  = (tick_now >= 48'd30) ? tick_now - $urandom_range(0, 30)
                                                  : tick_now;
            if ($urandom_range(0, 25) == 0) w.sample_time = rand48();
            w.current_time = ($urandom_range(0, 30) == 0) ? rand48() : tick_now;
            w.subwindow_length = ($urandom_range(0, 5) == 0) ? rand48()
                                                             : 48'($urandom_range(0, 40));
            send_word(w);
        end
    endtask

    initial begin
        ledger = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset window of 10 ticks: queries on an empty
        // ring, extreme values and times, a sample that is stale on arrival and
        // evicts itself, subwindows of zero and of the full range, and flushes.
        send_word(make_word(MODE_ALL, '0, '0, '0, '0));
        send_word(make_word(MODE_SUB, '1, TIME_MAX, TIME_MAX, TIME_MAX));
        send_word(make_word(MODE_FLUSH, '0, '0, '0, '0));
        send_word(make_word(MODE_ADD, 32'h0, 48'd100, 48'd100, '0));
        send_word(make_word(MODE_ADD, 32'hFFFF_FFFF, 48'd100, 48'd105, '0));
        send_word(make_word(MODE_ADD, 32'h1234_5678, 48'd105, 48'd105, '0));
        send_word(make_word(MODE_ALL, '0, '0, 48'd105, '0));
        send_word(make_word(MODE_SUB, '0, '0, 48'd105, 48'd0));
        send_word(make_word(MODE_SUB, '0, '0, TIME_MAX, TIME_MAX));
        send_word(make_word(MODE_ADD, 32'd1, 48'd0, 48'd200, '0));
        send_word(make_word(MODE_ALL, '0, '0, '0, '0));
        send_word(make_word(MODE_ADD, 32'd7, TIME_MAX, TIME_MAX, '0));
        send_word(make_word(MODE_ADD, 32'hFFFF_FFFF, TIME_MAX, 48'd0, '0));
        send_word(make_word(MODE_ALL, '0, '0, '0, '0));
        send_word(make_word(MODE_SUB, '0, '0, TIME_MAX, 48'd0));
        send_word(make_word(MODE_FLUSH, '0, '0, '0, '0));
        send_word(make_word(MODE_ALL, '0, '0, '0, '0));

        // Zero window: only samples stamped at or after the present time survive.
        write_window(48'd0);
        send_word(make_word(MODE_ADD, 32'd50, 48'd50, 48'd50, '0));
        send_word(make_word(MODE_ADD, 32'd49, 48'd49, 48'd50, '0));
        send_word(make_word(MODE_ADD, 32'd51, 48'd51, 48'd51, '0));
        send_word(make_word(MODE_SUB, '0, '0, 48'd51, 48'd1));
        tick_now = 48'd1000;
        run_random(150, 60, 3);

        // Largest window: nothing ages out, so the ring can fill and overflow between flushes.
        write_window(TIME_MAX);
        run_random(420, 80, 1);

        write_window(48'd1);
        run_random(120, 60, 4);

        write_window(48'd1000);
        run_random(150, 60, 3);

        write_window(rand48());
        run_random(80, 60, 5);

        drain();
        repeat (40) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
